FILE: src/ocg_pkg.sv
// Shared types, codes and default sizes of the OLED command and display RAM block.
package ocg_pkg;

   // Default sizes
   localparam int DEF_DISPLAY_WIDTH = 128;
   localparam int DEF_PAGE_COUNT    = 8;
   localparam int DEF_BUFFER_BYTES  = 1024;

   // Request field widths
   localparam int KIND_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int PIXX_W  = 7;
   localparam int PIXY_W  = 6;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

   // Command opcodes
   localparam logic [7:0] CMD_COL_LOW_LAST  = 8'h0F;
   localparam logic [7:0] CMD_COL_HIGH_LAST = 8'h1F;
   localparam logic [7:0] CMD_SET_MODE      = 8'h20;
   localparam logic [7:0] CMD_COL_WINDOW    = 8'h21;
   localparam logic [7:0] CMD_PAGE_WINDOW   = 8'h22;
   localparam logic [7:0] CMD_SHOW_RAM      = 8'hA4;
   localparam logic [7:0] CMD_INVERSE_OFF   = 8'hA6;
   localparam logic [7:0] CMD_DISPLAY_OFF   = 8'hAE;
   localparam logic [7:0] CMD_PAGE_SELECT   = 8'hB0;

   // Addressing modes
   localparam logic [1:0] MODE_HORIZ = 2'd0;
   localparam logic [1:0] MODE_VERT  = 2'd1;
   localparam logic [1:0] MODE_PAGE  = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK
   } state_type;

endpackage

FILE: src/ocg_if.sv
// Valid/ready channel interfaces for requests and pixel responses.
interface ocg_req_if;
   import ocg_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] data_byte;
   logic              dc_level;
   logic [PIXX_W-1:0] pixel_x;
   logic [PIXY_W-1:0] pixel_y;

   modport source (output valid, kind, data_byte, dc_level, pixel_x, pixel_y, input ready);
   modport sink   (input valid, kind, data_byte, dc_level, pixel_x, pixel_y, output ready);
endinterface

interface ocg_rsp_if;
   logic valid;
   logic ready;
   logic pixel_lit;

   modport source (output valid, pixel_lit, input ready);
   modport sink   (input valid, pixel_lit, output ready);
endinterface

FILE: src/ocg_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module ocg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/oled_controller_command_and_gram.sv
// Top level: transaction buffer, command decoder, display RAM writer and pixel query.
//
//   channel   direction  payload                                        handshake
//   req_port  in         kind, data_byte, dc_level, pixel_x, pixel_y    valid & ready
//   rsp_port  out        pixel_lit                                      valid & ready
//
// A data end walks the buffer at one byte per cycle through the buffer RAM read port, then
// makes the last display RAM write before the next request is taken. A query reads the
// display RAM into its read register; the result then lands in the response register, or
// in the skid stage while that is full, and requests are held off until it lands. After
// reset and after a reset request the display RAM is cleared, one entry per cycle, over
// all DISPLAY_WIDTH * PAGE_COUNT entries, with requests held off. A response waiting on a
// stalled rsp_port plus one in the skid stage holds off further requests.
module oled_controller_command_and_gram #(
   parameter int DISPLAY_WIDTH = ocg_pkg::DEF_DISPLAY_WIDTH,
   parameter int PAGE_COUNT    = ocg_pkg::DEF_PAGE_COUNT,
   parameter int BUFFER_BYTES  = ocg_pkg::DEF_BUFFER_BYTES
) (
   input logic        clock,
   input logic        reset,
   ocg_req_if.sink    req_port,
   ocg_rsp_if.source  rsp_port
);
   import ocg_pkg::*;

   localparam int COL_W      = $clog2(DISPLAY_WIDTH);
   localparam int PAGE_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int DRAM_DEPTH = DISPLAY_WIDTH * PAGE_COUNT;
   localparam int DADDR_W    = $clog2(DRAM_DEPTH);
   localparam int BUF_AW     = $clog2(BUFFER_BYTES);

   localparam logic [7:0]         COL_LIMIT  = 8'(DISPLAY_WIDTH);
   localparam logic [3:0]         PAGE_LIMIT = 4'(PAGE_COUNT);
   localparam logic [BUF_AW-1:0]  COUNT_MAX  = BUF_AW'(BUFFER_BYTES - 1);
   localparam logic [DADDR_W-1:0] CLEAR_LAST = DADDR_W'(DRAM_DEPTH - 1);

   // Control state
   state_type           state_ff, state_in;
   logic [DADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [BUF_AW-1:0]   byte_count_ff, byte_count_in;
   logic [3:0]          col_low_ff, col_low_in;
   logic [3:0]          col_high_ff, col_high_in;
   logic [1:0]          mode_ff, mode_in;
   logic [6:0]          win_col_start_ff, win_col_start_in;
   logic [6:0]          win_col_end_ff, win_col_end_in;
   logic [2:0]          win_page_start_ff, win_page_start_in;
   logic [2:0]          win_page_end_ff, win_page_end_in;
   logic [2:0]          sel_page_ff, sel_page_in;
   logic                display_enabled_ff, display_enabled_in;
   logic                show_ram_ff, show_ram_in;
   logic                inverse_video_ff, inverse_video_in;
   logic                wr_pend_ff, wr_pend_in;
   logic                q_pend_ff, q_pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                skid_valid_ff, skid_valid_in;

   // Payload state
   logic [7:0]          head0_ff, head0_in;
   logic [7:0]          head1_ff, head1_in;
   logic [7:0]          head2_ff, head2_in;
   logic [2:0]          walk_page_ff, walk_page_in;
   logic [6:0]          walk_col_ff, walk_col_in;
   logic [BUF_AW-1:0]   walk_used_ff, walk_used_in;
   logic [BUF_AW-1:0]   walk_last_ff, walk_last_in;
   logic [DADDR_W-1:0]  wr_addr_ff, wr_addr_in;
   logic [2:0]          q_bit_ff, q_bit_in;
   logic                q_force_ff, q_force_in;
   logic                q_force_val_ff, q_force_val_in;
   logic                q_inv_ff, q_inv_in;
   logic                rsp_lit_ff, rsp_lit_in;
   logic                skid_lit_ff, skid_lit_in;

   // Memory ports
   logic                buf_wr_en, buf_rd_en;
   logic [BUF_AW-1:0]   buf_wr_addr, buf_rd_addr;
   logic [7:0]          buf_wr_data, buf_rd_data;
   logic                dram_wr_en, dram_rd_en;
   logic [DADDR_W-1:0]  dram_wr_addr, dram_rd_addr;
   logic [7:0]          dram_wr_data, dram_rd_data;

   // Working signals
   logic                req_ready, req_accept;
   logic                q_lit, q_out_range;
   logic [7:0]          page_start_col;
   logic                walk_nonempty;
   logic                walk_done;
   logic [7:0]          col_next;
   logic [3:0]          page_next;

   // Display RAM address of a page and column
   function automatic logic [DADDR_W-1:0] ram_addr(input logic [2:0] page,
                                                   input logic [6:0] col);
      return DADDR_W'(page[PAGE_W-1:0]) * DADDR_W'(DISPLAY_WIDTH) + DADDR_W'(col[COL_W-1:0]);
   endfunction

   ocg_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_buf_ram (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (buf_wr_addr),
      .wr_data (buf_wr_data),
      .rd_en   (buf_rd_en),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   ocg_ram #(.WIDTH(8), .DEPTH(DRAM_DEPTH)) u_disp_ram (
      .clock   (clock),
      .wr_en   (dram_wr_en),
      .wr_addr (dram_wr_addr),
      .wr_data (dram_wr_data),
      .rd_en   (dram_rd_en),
      .rd_addr (dram_rd_addr),
      .rd_data (dram_rd_data)
   );

   // Accept only when idle with no display RAM write, query or skid entry outstanding
   assign req_ready  = (state_ff == ST_IDLE) && !wr_pend_ff && !q_pend_ff && !skid_valid_ff;
   assign req_accept = req_port.valid && req_ready;
   assign req_port.ready     = req_ready;
   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.pixel_lit = rsp_lit_ff;

   // Next state, memory controls and register updates
   always_comb begin
      state_in           = state_ff;
      clr_cnt_in         = clr_cnt_ff;
      byte_count_in      = byte_count_ff;
      col_low_in         = col_low_ff;
      col_high_in        = col_high_ff;
      mode_in            = mode_ff;
      win_col_start_in   = win_col_start_ff;
      win_col_end_in     = win_col_end_ff;
      win_page_start_in  = win_page_start_ff;
      win_page_end_in    = win_page_end_ff;
      sel_page_in        = sel_page_ff;
      display_enabled_in = display_enabled_ff;
      show_ram_in        = show_ram_ff;
      inverse_video_in   = inverse_video_ff;
      head0_in           = head0_ff;
      head1_in           = head1_ff;
      head2_in           = head2_ff;
      walk_page_in       = walk_page_ff;
      walk_col_in        = walk_col_ff;
      walk_used_in       = walk_used_ff;
      walk_last_in       = walk_last_ff;
      wr_addr_in         = wr_addr_ff;
      q_bit_in           = q_bit_ff;
      q_force_in         = q_force_ff;
      q_force_val_in     = q_force_val_ff;
      q_inv_in           = q_inv_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_lit_in         = rsp_lit_ff;
      skid_valid_in      = skid_valid_ff;
      skid_lit_in        = skid_lit_ff;
      wr_pend_in         = 1'b0;
      q_pend_in          = 1'b0;

      buf_wr_en    = 1'b0;
      buf_wr_addr  = byte_count_ff;
      buf_wr_data  = req_port.data_byte;
      buf_rd_en    = 1'b0;
      buf_rd_addr  = walk_used_ff;
      dram_wr_en   = wr_pend_ff;
      dram_wr_addr = wr_addr_ff;
      dram_wr_data = buf_rd_data;
      dram_rd_en   = 1'b0;
      dram_rd_addr = ram_addr(req_port.pixel_y[5:3], req_port.pixel_x);

      q_out_range    = ({1'b0, req_port.pixel_x} >= COL_LIMIT) ||
                       ({1'b0, req_port.pixel_y[5:3]} >= PAGE_LIMIT) || !display_enabled_ff;
      q_lit          = q_force_ff ? q_force_val_ff : (dram_rd_data[q_bit_ff] ^ q_inv_ff);
      page_start_col = {col_high_ff, col_low_ff};
      walk_nonempty  = 1'b0;
      walk_done      = 1'b0;
      col_next       = {1'b0, walk_col_ff} + 8'd1;
      page_next      = {1'b0, walk_page_ff} + 4'd1;

      // Drain the response register, then refill it from the skid stage
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in  = skid_valid_ff;
         rsp_lit_in    = skid_lit_ff;
         skid_valid_in = 1'b0;
      end

      // Land a query result in the response register or the skid stage
      if (q_pend_ff) begin
         if (!rsp_valid_in) begin
            rsp_valid_in = 1'b1;
            rsp_lit_in   = q_lit;
         end else begin
            skid_valid_in = 1'b1;
            skid_lit_in   = q_lit;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            // Sweep the display RAM with zeros
            dram_wr_en   = 1'b1;
            dram_wr_addr = clr_cnt_ff;
            dram_wr_data = '0;
            if (clr_cnt_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + DADDR_W'(1);
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               case (req_port.kind)
                  KIND_BYTE: begin
                     // Store the byte unless the buffer is full; keep the first three
                     if (byte_count_ff != COUNT_MAX) begin
                        buf_wr_en     = 1'b1;
                        byte_count_in = byte_count_ff + BUF_AW'(1);
                        if (byte_count_ff == BUF_AW'(0)) begin
                           head0_in = req_port.data_byte;
                        end
                        if (byte_count_ff == BUF_AW'(1)) begin
                           head1_in = req_port.data_byte;
                        end
                        if (byte_count_ff == BUF_AW'(2)) begin
                           head2_in = req_port.data_byte;
                        end
                     end
                  end

                  KIND_END: begin
                     byte_count_in = '0;
                     if (byte_count_ff != BUF_AW'(0)) begin
                        if (req_port.dc_level) begin
                           // Set up the data walk at the window start, or at the page start column in page mode
                           case (mode_ff)
                              MODE_HORIZ, MODE_VERT: begin
                                 walk_nonempty = (win_page_start_ff < win_page_end_ff) &&
                                                 (win_col_start_ff < win_col_end_ff);
                                 walk_page_in  = win_page_start_ff;
                                 walk_col_in   = win_col_start_ff;
                              end
                              MODE_PAGE: begin
                                 walk_nonempty = page_start_col < COL_LIMIT;
                                 walk_page_in  = sel_page_ff;
                                 walk_col_in   = page_start_col[6:0];
                              end
                              default: begin
                                 walk_nonempty = 1'b0;
                              end
                           endcase
                           if (walk_nonempty) begin
                              state_in     = ST_WALK;
                              walk_used_in = '0;
                              walk_last_in = byte_count_ff - BUF_AW'(1);
                           end
                        end else begin
                           // Decode the first byte as a command
                           if (head0_ff <= CMD_COL_LOW_LAST) begin
                              col_low_in = head0_ff[3:0];
                           end else if (head0_ff <= CMD_COL_HIGH_LAST) begin
                              col_high_in = head0_ff[3:0];
                           end else if (head0_ff == CMD_SET_MODE) begin
                              if (byte_count_ff >= BUF_AW'(2)) begin
                                 mode_in = head1_ff[1:0];
                              end
                           end else if (head0_ff == CMD_COL_WINDOW) begin
                              if (byte_count_ff >= BUF_AW'(2)) begin
                                 win_col_start_in = head1_ff[6:0];
                              end
                              if (byte_count_ff >= BUF_AW'(3)) begin
                                 win_col_end_in = head2_ff[6:0];
                              end
                           end else if (head0_ff == CMD_PAGE_WINDOW) begin
                              if (byte_count_ff >= BUF_AW'(2)) begin
                                 win_page_start_in = head1_ff[2:0];
                              end
                              if (byte_count_ff >= BUF_AW'(3)) begin
                                 win_page_end_in = head2_ff[2:0];
                              end
                           end else if (head0_ff[7:1] == CMD_SHOW_RAM[7:1]) begin
                              show_ram_in = !head0_ff[0];
                           end else if (head0_ff[7:1] == CMD_INVERSE_OFF[7:1]) begin
                              inverse_video_in = head0_ff[0];
                           end else if (head0_ff[7:1] == CMD_DISPLAY_OFF[7:1]) begin
                              display_enabled_in = head0_ff[0];
                           end else if (head0_ff[7:3] == CMD_PAGE_SELECT[7:3]) begin
                              sel_page_in = head0_ff[2:0];
                           end
                        end
                     end
                  end

                  KIND_RESET: begin
                     // Restore register defaults and start the clearing sweep
                     state_in           = ST_CLEAR;
                     clr_cnt_in         = '0;
                     byte_count_in      = '0;
                     col_low_in         = '0;
                     col_high_in        = '0;
                     mode_in            = MODE_PAGE;
                     win_col_start_in   = '0;
                     win_col_end_in     = '0;
                     win_page_start_in  = '0;
                     win_page_end_in    = '0;
                     sel_page_in        = '0;
                     display_enabled_in = 1'b0;
                     show_ram_in        = 1'b1;
                     inverse_video_in   = 1'b0;
                  end

                  KIND_QUERY: begin
                     // Read the column byte; settle forced results now
                     dram_rd_en     = 1'b1;
                     q_pend_in      = 1'b1;
                     q_bit_in       = req_port.pixel_y[2:0];
                     q_force_in     = q_out_range || !show_ram_ff;
                     q_force_val_in = !q_out_range;
                     q_inv_in       = inverse_video_ff;
                  end

                  default: begin
                  end
               endcase
            end
         end

         ST_WALK: begin
            // Read the next byte; its display RAM write, if in range, follows in the next cycle
            buf_rd_en  = 1'b1;
            wr_pend_in = ({1'b0, walk_page_ff} < PAGE_LIMIT) &&
                         ({1'b0, walk_col_ff} < COL_LIMIT);
            wr_addr_in = ram_addr(walk_page_ff, walk_col_ff);

            // Advance the position within the window
            case (mode_ff)
               MODE_HORIZ: begin
                  if (col_next < {1'b0, win_col_end_ff}) begin
                     walk_col_in = col_next[6:0];
                  end else if (page_next < {1'b0, win_page_end_ff}) begin
                     walk_col_in  = win_col_start_ff;
                     walk_page_in = page_next[2:0];
                  end else begin
                     walk_done = 1'b1;
                  end
               end
               MODE_VERT: begin
                  if (page_next < {1'b0, win_page_end_ff}) begin
                     walk_page_in = page_next[2:0];
                  end else if (col_next < {1'b0, win_col_end_ff}) begin
                     walk_page_in = win_page_start_ff;
                     walk_col_in  = col_next[6:0];
                  end else begin
                     walk_done = 1'b1;
                  end
               end
               MODE_PAGE: begin
                  if (col_next < COL_LIMIT) begin
                     walk_col_in = col_next[6:0];
                  end else begin
                     walk_done = 1'b1;
                  end
               end
               default: begin
                  walk_done = 1'b1;
               end
            endcase

            walk_used_in = walk_used_ff + BUF_AW'(1);
            if (walk_done || (walk_used_ff == walk_last_ff)) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff         <= '0;
         byte_count_ff      <= '0;
         col_low_ff         <= '0;
         col_high_ff        <= '0;
         mode_ff            <= MODE_PAGE;
         win_col_start_ff   <= '0;
         win_col_end_ff     <= '0;
         win_page_start_ff  <= '0;
         win_page_end_ff    <= '0;
         sel_page_ff        <= '0;
         display_enabled_ff <= 1'b0;
         show_ram_ff        <= 1'b1;
         inverse_video_ff   <= 1'b0;
         wr_pend_ff         <= 1'b0;
         q_pend_ff          <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
      end else begin
         clr_cnt_ff         <= clr_cnt_in;
         byte_count_ff      <= byte_count_in;
         col_low_ff         <= col_low_in;
         col_high_ff        <= col_high_in;
         mode_ff            <= mode_in;
         win_col_start_ff   <= win_col_start_in;
         win_col_end_ff     <= win_col_end_in;
         win_page_start_ff  <= win_page_start_in;
         win_page_end_ff    <= win_page_end_in;
         sel_page_ff        <= sel_page_in;
         display_enabled_ff <= display_enabled_in;
         show_ram_ff        <= show_ram_in;
         inverse_video_ff   <= inverse_video_in;
         wr_pend_ff         <= wr_pend_in;
         q_pend_ff          <= q_pend_in;
         rsp_valid_ff       <= rsp_valid_in;
         skid_valid_ff      <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      head0_ff       <= head0_in;
      head1_ff       <= head1_in;
      head2_ff       <= head2_in;
      walk_page_ff   <= walk_page_in;
      walk_col_ff    <= walk_col_in;
      walk_used_ff   <= walk_used_in;
      walk_last_ff   <= walk_last_in;
      wr_addr_ff     <= wr_addr_in;
      q_bit_ff       <= q_bit_in;
      q_force_ff     <= q_force_in;
      q_force_val_ff <= q_force_val_in;
      q_inv_ff       <= q_inv_in;
      rsp_lit_ff     <= rsp_lit_in;
      skid_lit_ff    <= skid_lit_in;
   end

endmodule
